// ----- rtl/bls_pkg.sv -----
// shared constants and types for the bresenham line stepper
package bls_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned COLOR_BITS     = 24;
  // command queue depth, kept a power of two so the pointers wrap on their own
  localparam int unsigned QUEUE_DEPTH    = 2;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

endpackage

// ----- rtl/bls_front.sv -----
// front end: accepts requests, classifies them and precomputes line setup
module bls_front #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  // x_start, y_start, x_end, y_end, line_color, zero fill
  input  logic [((4*COORD_BITS+bls_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // req_type
  input  logic                                                  s_axis_tuser_i,
  input  logic                                                  s_axis_tvalid_i,
  output logic                                                  s_axis_tready_o,
  input  logic                                                  q_full_i,
  output logic                                                  q_push_o,
  output logic [6*COORD_BITS+bls_pkg::COLOR_BITS+3:0]           q_entry_o
);

  localparam int unsigned C = COORD_BITS;

  logic signed [C-1:0]   xs, ys, xe, ye;
  logic [bls_pkg::COLOR_BITS-1:0] color;
  logic signed [C:0]     diff_x, diff_y;
  logic [C-1:0]          dx, dy;
  logic                  x_down, y_down, same;
  bls_pkg::req_e         req;

  assign xs    = $signed(s_axis_tdata_i[C-1:0]);
  assign ys    = $signed(s_axis_tdata_i[2*C-1:C]);
  assign xe    = $signed(s_axis_tdata_i[3*C-1:2*C]);
  assign ye    = $signed(s_axis_tdata_i[4*C-1:3*C]);
  assign color = s_axis_tdata_i[4*C+bls_pkg::COLOR_BITS-1:4*C];
  assign req   = bls_pkg::req_e'(s_axis_tuser_i);

  assign diff_x = {xe[C-1], xe} - {xs[C-1], xs};
  assign diff_y = {ye[C-1], ye} - {ys[C-1], ys};

  // magnitudes always fit in C unsigned bits
  always_comb begin
    logic signed [C:0] neg_x, neg_y;
    neg_x = -diff_x;
    neg_y = -diff_y;
    dx = diff_x[C] ? neg_x[C-1:0] : diff_x[C-1:0];
    dy = diff_y[C] ? neg_y[C-1:0] : diff_y[C-1:0];
  end

  assign x_down = !(xs < xe);
  assign y_down = !(ys < ye);
  assign same   = (xs == xe) && (ys == ye);

  assign s_axis_tready_o = !q_full_i;
  assign q_push_o        = s_axis_tvalid_i && !q_full_i;
  assign q_entry_o       = {color, same, y_down, x_down, dy, dx,
                            ye, xe, ys, xs, (req == bls_pkg::REQ_STEP)};

endmodule

// ----- rtl/bls_queue.sv -----
// short command queue between the front end and the stepping back end
module bls_queue #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned DEPTH = bls_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = mem_q[rptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_comb begin
    wptr_d  = do_push ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = do_pop  ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/bls_back.sv -----
// back end: holds the active line, runs the error rule and drives the pixel output
module bls_back #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic                                                 clk_i,
  input  logic                                                 rst_ni,
  input  logic                                                 q_valid_i,
  input  logic [6*COORD_BITS+bls_pkg::COLOR_BITS+3:0]          q_entry_i,
  output logic                                                 q_pop_o,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+bls_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // last_pixel
  output logic                                                 m_axis_tlast_o,
  output logic                                                 m_axis_tvalid_o,
  input  logic                                                 m_axis_tready_i
);

  localparam int unsigned C     = COORD_BITS;
  localparam int unsigned CB    = bls_pkg::COLOR_BITS;
  localparam int unsigned OUT_W = ((2*C+CB+7)/8)*8;

  // queue entry fields
  logic          e_step, e_xdown, e_ydown, e_same;
  logic [C-1:0]  e_xs, e_ys, e_xe, e_ye, e_dx, e_dy;
  logic [CB-1:0] e_color;

  assign e_step  = q_entry_i[0];
  assign e_xs    = q_entry_i[C:1];
  assign e_ys    = q_entry_i[2*C:C+1];
  assign e_xe    = q_entry_i[3*C:2*C+1];
  assign e_ye    = q_entry_i[4*C:3*C+1];
  assign e_dx    = q_entry_i[5*C:4*C+1];
  assign e_dy    = q_entry_i[6*C:5*C+1];
  assign e_xdown = q_entry_i[6*C+1];
  assign e_ydown = q_entry_i[6*C+2];
  assign e_same  = q_entry_i[6*C+3];
  assign e_color = q_entry_i[6*C+CB+3:6*C+4];

  // line state
  logic [C-1:0]          cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [C-1:0]          tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [C-1:0]          dx_q, dx_d, dy_q, dy_d;
  logic                  xdown_q, xdown_d, ydown_q, ydown_d;
  logic signed [C+1:0]   err_q, err_d;
  logic [CB-1:0]         color_q, color_d;
  logic                  active_q, active_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [C-1:0]          out_x_q, out_x_d, out_y_q, out_y_d;
  logic [CB-1:0]         out_color_q, out_color_d;
  logic                  out_last_q, out_last_d;

  logic                  pop;
  logic signed [C+2:0]   e2, neg_dy, pos_dx, err_sum;
  logic                  x_move, y_move;
  logic [C-1:0]          nx, ny;
  logic                  is_step;

  assign pop     = q_valid_i && (!out_valid_q || m_axis_tready_i);
  assign q_pop_o = pop;
  assign is_step = (bls_pkg::req_e'(e_step) == bls_pkg::REQ_STEP);

  assign e2     = {err_q, 1'b0};
  assign neg_dy = -$signed({3'b000, dy_q});
  assign pos_dx = $signed({3'b000, dx_q});
  assign x_move = (e2 > neg_dy);
  assign y_move = (e2 < pos_dx);
  assign err_sum = $signed({err_q[C+1], err_q})
                   - (x_move ? $signed({3'b000, dy_q}) : '0)
                   + (y_move ? pos_dx : '0);
  assign nx = x_move ? (xdown_q ? cur_x_q - 1'b1 : cur_x_q + 1'b1) : cur_x_q;
  assign ny = y_move ? (ydown_q ? cur_y_q - 1'b1 : cur_y_q + 1'b1) : cur_y_q;

  always_comb begin
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    xdown_d     = xdown_q;
    ydown_d     = ydown_q;
    err_d       = err_q;
    color_d     = color_q;
    active_d    = active_q;
    out_x_d     = out_x_q;
    out_y_d     = out_y_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (pop) begin
      if (!is_step) begin
        cur_x_d     = e_xs;
        cur_y_d     = e_ys;
        tgt_x_d     = e_xe;
        tgt_y_d     = e_ye;
        dx_d        = e_dx;
        dy_d        = e_dy;
        xdown_d     = e_xdown;
        ydown_d     = e_ydown;
        err_d       = $signed({2'b00, e_dx}) - $signed({2'b00, e_dy});
        color_d     = e_color;
        active_d    = !e_same;
        out_x_d     = e_xe;
        out_y_d     = e_ye;
        out_color_d = e_color;
        out_last_d  = e_same;
        out_valid_d = 1'b1;
      end else if (active_q) begin
        cur_x_d     = nx;
        cur_y_d     = ny;
        err_d       = err_sum[C+1:0];
        out_x_d     = cur_x_q;
        out_y_d     = cur_y_q;
        out_color_d = color_q;
        out_last_d  = (nx == tgt_x_q) && (ny == tgt_y_q);
        active_d    = !out_last_d;
        out_valid_d = 1'b1;
      end else begin
        // step with no line in progress is dropped
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q     <= cur_x_d;
    cur_y_q     <= cur_y_d;
    tgt_x_q     <= tgt_x_d;
    tgt_y_q     <= tgt_y_d;
    dx_q        <= dx_d;
    dy_q        <= dy_d;
    xdown_q     <= xdown_d;
    ydown_q     <= ydown_d;
    err_q       <= err_d;
    color_q     <= color_d;
    out_x_q     <= out_x_d;
    out_y_q     <= out_y_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = OUT_W'({out_color_q, out_y_q, out_x_q});

endmodule

// ----- rtl/bresenham_line_stepper.sv -----
// bresenham line stepper top level: front end, command queue and stepping back end
//
// input stream carries one request per transaction: tuser = 0 loads a new line
// (start point, end point, color in tdata), tuser = 1 asks for the next pixel.
// a load answers with the end pixel right away, tlast set if start equals end.
// each step answers with the current pixel and moves one step along the line;
// tlast marks the step that reaches the end. a step with no line in progress
// gives no output transaction. a load always replaces the line in progress.
// an accepted request is registered first in the command queue and then in the
// output register, where its result becomes valid.
// throughput: one request per cycle unless the output stalls, set by the single
// error update and position increment in the back end, which run once per queue pop.
// when the receiver stalls, the output register holds its pixel, the back end
// stops popping, and the two-entry queue fills before s_axis_tready_o drops.
// reset empties the queue, clears the output valid and ends any active line.
module bresenham_line_stepper #(
  parameter int unsigned COORD_BITS = bls_pkg::COORD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // x_start, y_start, x_end, y_end, line_color, zero fill
  input  logic [((4*COORD_BITS+bls_pkg::COLOR_BITS+7)/8)*8-1:0] s_axis_tdata_i,
  // req_type
  input  logic                                                  s_axis_tuser_i,
  input  logic                                                  s_axis_tvalid_i,
  output logic                                                  s_axis_tready_o,
  // pixel_x, pixel_y, pixel_color, zero fill
  output logic [((2*COORD_BITS+bls_pkg::COLOR_BITS+7)/8)*8-1:0] m_axis_tdata_o,
  // last_pixel
  output logic                                                  m_axis_tlast_o,
  output logic                                                  m_axis_tvalid_o,
  input  logic                                                  m_axis_tready_i
);

  localparam int unsigned ENTRY_W = 6*COORD_BITS + bls_pkg::COLOR_BITS + 4;

  logic               q_full, q_push, q_pop, q_valid;
  logic [ENTRY_W-1:0] q_wdata, q_rdata;

  bls_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .q_full_i        (q_full),
    .q_push_o        (q_push),
    .q_entry_o       (q_wdata)
  );

  bls_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_rdata)
  );

  bls_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .q_entry_i       (q_rdata),
    .q_pop_o         (q_pop),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i)
  );

endmodule
